>>> hdl/ppmfg_pkg.sv
// ----------------------------------------------------------------------------
// ppmfg_pkg
// Shared widths, codes and reset values of the PPM frame generator.
// ----------------------------------------------------------------------------
package ppmfg_pkg;

  // Field widths.
  localparam int OpW      = 1;
  localparam int ChanW    = 3;
  localparam int ValW     = 16;
  localparam int TpuW     = 8;
  localparam int TickW    = 16;
  localparam int SlotW    = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Default number of channels in a frame.
  localparam int NumChannelsDefault = 5;

  // Item opcodes.
  localparam logic [OpW-1:0] OpTick  = 1'b0;
  localparam logic [OpW-1:0] OpWrite = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTicksPerUs = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameTicks = 2'd2;

  // Configuration reset values.
  localparam logic [TpuW-1:0]  TicksPerUsRst = 8'd2;
  localparam logic [TickW-1:0] PulseTicksRst = 16'd600;
  localparam logic [TickW-1:0] FrameTicksRst = 16'd45000;

  // Slot code held during the padding interval; stands for minus one.
  localparam logic [SlotW-1:0] SlotWrap = 4'hF;

endpackage

>>> hdl/ppmfg_if.sv
// ----------------------------------------------------------------------------
// ppmfg_in_if / ppmfg_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface ppmfg_in_if;
  logic                        valid;
  logic                        ready;
  logic [ppmfg_pkg::OpW-1:0]   opcode;
  logic [ppmfg_pkg::ChanW-1:0] channel_index;
  logic [ppmfg_pkg::ValW-1:0]  value_us;

  modport source (output valid, output opcode, output channel_index, output value_us,
                  input ready);
  modport sink   (input valid, input opcode, input channel_index, input value_us,
                  output ready);
endinterface

interface ppmfg_out_if;
  logic valid;
  logic ready;
  logic ppm_level;
  logic frame_start;

  modport source (output valid, output ppm_level, output frame_start, input ready);
  modport sink   (input valid, input ppm_level, input frame_start, output ready);
endinterface

>>> hdl/ppm_frame_generator.sv
// ----------------------------------------------------------------------------
// ppm_frame_generator
// RC pulse-position frame encoder driven by tick and channel-write items.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle and returns one result for each
// item, in order, through an output register; a stalled output holds the
// pipeline. Items pass an input stage, which reads the old value of the
// addressed channel and scales the new one, and an execute stage, which
// updates the timing state and writes the channel memory. The channel
// memory has one write port and two read ports; the port that serves ticks
// always prefetches the entry of the current slot, and same-cycle writes are
// forwarded, so the sustained rate is one item per cycle. Channel entries
// read as zero after reset through per-entry valid bits; no clearing pass runs.
module ppm_frame_generator #(
  parameter int NUM_CHANNELS = ppmfg_pkg::NumChannelsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppmfg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ppmfg_pkg::CfgDataW-1:0]   cfg_data_i,
  ppmfg_in_if.sink                         in_i,
  ppmfg_out_if.source                      out_o
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TickW = ppmfg_pkg::TickW;
  localparam int SlotW = ppmfg_pkg::SlotW;

  // Configuration registers.
  logic [ppmfg_pkg::TpuW-1:0] tpu_q;
  logic [TickW-1:0]           pulse_q, frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= ppmfg_pkg::TicksPerUsRst;
      pulse_q <= ppmfg_pkg::PulseTicksRst;
      frame_q <= ppmfg_pkg::FrameTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppmfg_pkg::CfgTicksPerUs: tpu_q   <= cfg_data_i[ppmfg_pkg::TpuW-1:0];
        ppmfg_pkg::CfgPulseTicks: pulse_q <= cfg_data_i;
        ppmfg_pkg::CfgFrameTicks: frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic s1_vld_q, out_vld_q;
  logic advance, accept, exec;

  assign advance    = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || advance;
  assign accept     = in_i.valid && in_i.ready;
  assign exec       = s1_vld_q && advance;

  // Input stage: range check and scaling of the written value.
  logic                        in_range;
  logic [IdxW-1:0]             in_idx;
  logic [TickW+ppmfg_pkg::TpuW-1:0] prod;
  logic [TickW-1:0]            scaled;

  assign in_range = ({1'b0, in_i.channel_index} < (ppmfg_pkg::ChanW+1)'(NUM_CHANNELS));
  assign in_idx   = in_range ? in_i.channel_index[IdxW-1:0] : '0;
  assign prod     = in_i.value_us * tpu_q;
  assign scaled   = prod[TickW-1:0] - pulse_q;

  logic [ppmfg_pkg::OpW-1:0] s1_op_q;
  logic                      s1_range_q;
  logic [IdxW-1:0]           s1_idx_q;
  logic [TickW-1:0]          s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept || (s1_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_i.opcode;
      s1_range_q <= in_range;
      s1_idx_q   <= in_idx;
      s1_val_q   <= scaled;
    end
  end

  // Execute-stage state.
  logic             line_q, line_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [TickW-1:0] cnt_q, cnt_d;
  logic [TickW-1:0] intv_q, intv_d;
  logic [TickW-1:0] pad_q, pad_d;
  logic [TickW-1:0] sum_q, sum_d;
  logic             fs_d;

  logic [TickW-1:0] slot_data, old_data, sum_new, total;
  logic             mem_we;
  logic [IdxW-1:0]  ra_addr;

  assign sum_new = sum_q - old_data + s1_val_q;
  assign total   = sum_new + TickW'(NUM_CHANNELS * pulse_q);
  assign mem_we  = exec && (s1_op_q == ppmfg_pkg::OpWrite) && s1_range_q;

  // Execute stage: tick timing and channel-write bookkeeping.
  always_comb begin
    line_d = line_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    intv_d = intv_q;
    pad_d  = pad_q;
    sum_d  = sum_q;
    fs_d   = 1'b0;
    if (exec) begin
      unique case (s1_op_q)
        ppmfg_pkg::OpWrite: begin
          if (s1_range_q) begin
            sum_d = sum_new;
            pad_d = frame_q - total;
          end
        end
        default: begin
          if (cnt_q == intv_q) begin
            cnt_d = '0;
            if (!line_q) begin
              intv_d = pulse_q;
              slot_d = slot_q + 1'b1;
              line_d = 1'b1;
            end else begin
              if (slot_q < SlotW'(NUM_CHANNELS)) begin
                intv_d = slot_data;
              end else begin
                intv_d = pad_q;
                slot_d = ppmfg_pkg::SlotWrap;
                fs_d   = 1'b1;
              end
              line_d = 1'b0;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= 1'b0;
      slot_q <= '0;
      cnt_q  <= '0;
      intv_q <= ppmfg_pkg::PulseTicksRst;
      pad_q  <= '0;
      sum_q  <= '0;
    end else begin
      line_q <= line_d;
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      intv_q <= intv_d;
      pad_q  <= pad_d;
      sum_q  <= sum_d;
    end
  end

  // Prefetch the entry of the slot that the next item will see.
  assign ra_addr = (slot_d < SlotW'(NUM_CHANNELS)) ? slot_d[IdxW-1:0] : '0;

  ppmfg_chan_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (s1_idx_q),
    .wdata_i   (s1_val_q),
    .ra_addr_i (ra_addr),
    .ra_data_o (slot_data),
    .rb_en_i   (accept),
    .rb_addr_i (in_idx),
    .rb_data_o (old_data)
  );

  // Output register.
  logic out_level_q, out_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= exec || (out_vld_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_level_q <= line_d;
      out_fs_q    <= fs_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.ppm_level   = out_level_q;
  assign out_o.frame_start = out_fs_q;

endmodule

>>> hdl/ppmfg_chan_store.sv
// ----------------------------------------------------------------------------
// ppmfg_chan_store
// Channel interval memory: one write port, two registered read ports, with
// forwarding of a same-cycle write and per-entry valid bits for the zero reset.
// ----------------------------------------------------------------------------
module ppmfg_chan_store #(
  parameter int NUM_CHANNELS = ppmfg_pkg::NumChannelsDefault,
  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IdxW-1:0]              waddr_i,
  input  logic [ppmfg_pkg::TickW-1:0]  wdata_i,
  input  logic [IdxW-1:0]              ra_addr_i,
  output logic [ppmfg_pkg::TickW-1:0]  ra_data_o,
  input  logic                         rb_en_i,
  input  logic [IdxW-1:0]              rb_addr_i,
  output logic [ppmfg_pkg::TickW-1:0]  rb_data_o
);

  logic [ppmfg_pkg::TickW-1:0] mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     valid_q;

  logic [ppmfg_pkg::TickW-1:0] ra_rdata_q, rb_rdata_q;
  logic [ppmfg_pkg::TickW-1:0] ra_fwd_q, rb_fwd_q;
  logic                        ra_vld_q, rb_vld_q;
  logic                        ra_hit_q, rb_hit_q;

  // Memory array: write port and two read ports, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_rdata_q <= mem_q[ra_addr_i];
    ra_fwd_q   <= wdata_i;
    if (rb_en_i) begin
      rb_rdata_q <= mem_q[rb_addr_i];
      rb_fwd_q   <= wdata_i;
    end
  end

  // Valid bits and forwarding flags; an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ra_vld_q <= 1'b0;
      ra_hit_q <= 1'b0;
      rb_vld_q <= 1'b0;
      rb_hit_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      ra_vld_q <= valid_q[ra_addr_i];
      ra_hit_q <= we_i && (waddr_i == ra_addr_i);
      if (rb_en_i) begin
        rb_vld_q <= valid_q[rb_addr_i];
        rb_hit_q <= we_i && (waddr_i == rb_addr_i);
      end
    end
  end

  // Resolved read data.
  assign ra_data_o = ra_hit_q ? ra_fwd_q : (ra_vld_q ? ra_rdata_q : '0);
  assign rb_data_o = rb_hit_q ? rb_fwd_q : (rb_vld_q ? rb_rdata_q : '0);

endmodule

>>> tb/ppmfg_tb_pkg.sv
// ----------------------------------------------------------------------------
// ppmfg_tb_pkg
// Line-level tracker and result checking for the PPM frame generator bench.
// ----------------------------------------------------------------------------
// The tracker keeps its own copy of the frame timing state and of the three
// configuration registers. Every accepted input transaction advances that
// state and queues the line level and frame-start flag it should produce.
// Every accepted output transaction is checked against the oldest entry.
// ----------------------------------------------------------------------------
package ppmfg_tb_pkg;

  import ppmfg_pkg::*;

  // Expected contents of one output transaction.
  typedef struct packed {
    logic level;
    logic frame_start;
  } ppm_result_t;

  class ppm_line_tracker;

    int unsigned channels;

    // Configuration copy.
    logic [TpuW-1:0]  ticks_per_us;
    logic [TickW-1:0] pulse_len;
    logic [TickW-1:0] frame_len;

    // Frame timing state.
    logic             line_high;
    logic [SlotW-1:0] slot;
    logic [TickW-1:0] tick_count;
    logic [TickW-1:0] interval;
    logic [TickW-1:0] padding;
    logic [TickW-1:0] channel_sum;
    logic [TickW-1:0] low_time [8];

    ppm_result_t      expected_levels [$];
    int unsigned      results_seen;
    int unsigned      errors;

    function new(int unsigned num_channels);
      channels     = num_channels;
      ticks_per_us = TicksPerUsRst;
      pulse_len    = PulseTicksRst;
      frame_len    = FrameTicksRst;
      line_high    = 1'b0;
      slot         = '0;
      tick_count   = '0;
      interval     = PulseTicksRst;
      padding      = '0;
      channel_sum  = '0;
      foreach (low_time[i]) low_time[i] = '0;
      results_seen = 0;
      errors       = 0;
    endfunction

    function void set_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgTicksPerUs: ticks_per_us = data[TpuW-1:0];
        CfgPulseTicks: pulse_len = data;
        CfgFrameTicks: frame_len = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    // Advance the timing state by one accepted item and queue its result.
    function void take_item(logic [OpW-1:0] op, logic [ChanW-1:0] chan,
                            logic [ValW-1:0] us);
      logic [31:0]      scaled;
      logic [TickW-1:0] low_ticks;
      ppm_result_t      res;
      res.frame_start = 1'b0;
      if (op == OpWrite) begin
        // Writes past the last channel leave everything untouched.
        if (chan < channels) begin
          scaled         = ticks_per_us * us;
          low_ticks      = scaled[TickW-1:0] - pulse_len;
          channel_sum    = channel_sum - low_time[chan] + low_ticks;
          low_time[chan] = low_ticks;
          padding        = frame_len - channel_sum - TickW'(channels * pulse_len);
        end
      end else if (tick_count == interval) begin
        // Interval expired: clear the counter and toggle the line.
        tick_count = '0;
        if (!line_high) begin
          interval  = pulse_len;
          slot      = slot + 1'b1;
          line_high = 1'b1;
        end else begin
          if (slot < channels) begin
            interval = low_time[slot[ChanW-1:0]];
          end else begin
            interval        = padding;
            slot            = SlotWrap;
            res.frame_start = 1'b1;
          end
          line_high = 1'b0;
        end
      end else begin
        tick_count = tick_count + 1'b1;
      end
      res.level = line_high;
      expected_levels.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one output transaction with the oldest expectation.
    task check_result(logic level, logic frame_start);
      ppm_result_t want;
      results_seen++;
      if (expected_levels.size() == 0) begin
        report($sformatf("result %0d (level %b, frame_start %b) with nothing outstanding",
                         results_seen, level, frame_start));
      end else begin
        want = expected_levels.pop_front();
        if (level !== want.level)
          report($sformatf("result %0d: ppm_level %b, expected %b",
                           results_seen, level, want.level));
        if (frame_start !== want.frame_start)
          report($sformatf("result %0d: frame_start %b, expected %b",
                           results_seen, frame_start, want.frame_start));
      end
    endtask

  endclass

endpackage

>>> tb/ppm_frame_generator_tb.sv
// ----------------------------------------------------------------------------
// ppm_frame_generator_tb
// Self-checking bench for the PPM frame generator.
// ----------------------------------------------------------------------------
// A short directed run at the reset configuration covers field extremes,
// ignored channel writes and wrapping channel arithmetic. Random phases with
// short pulses and small channel values then run the line through many full
// frames, including the skipped channel of the first frame, the padding
// interval and zero-length intervals. The last phases use extreme register
// values. Both handshake sides idle in random bursts, the receiver twice holds
// off long enough to stall the input, and the sender once drains the block.
// ----------------------------------------------------------------------------
module ppm_frame_generator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ppmfg_pkg::*;
  import ppmfg_tb_pkg::*;

  localparam int NumChannels = NumChannelsDefault;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 64;
  localparam int DrainCycles = 8;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ppmfg_in_if  in_if ();
  ppmfg_out_if out_if ();

  ppm_frame_generator #(
    .NUM_CHANNELS(NumChannels)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  ppm_line_tracker  tracker;

  // Idling control shared by the sender and the receiver.
  logic             idling;
  bit               hold_request;
  int               hold_left;
  int               rx_gap;
  int               stall_cycles = 0;

  // Register values in force, used to build well-formed channel writes.
  logic [TpuW-1:0]  cur_tpu;
  logic [TickW-1:0] cur_pulse;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random ready bursts, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_if.ready <= 1'b0;
      rx_gap--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      rx_gap = $urandom_range(0, 6);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: note accepted input transactions, check accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        tracker.take_item(in_if.opcode, in_if.channel_index, in_if.value_us);
      if (out_if.valid && out_if.ready)
        tracker.check_result(out_if.ppm_level, out_if.frame_start);
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("** ppm_frame_generator: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, after an optional idle burst, and wait for acceptance.
  task automatic send_item(input logic [OpW-1:0] op, input logic [ChanW-1:0] chan,
                           input logic [ValW-1:0] us);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.channel_index <= chan;
    in_if.value_us      <= us;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // The unused fields of a tick carry random noise.
  task automatic send_tick();
    send_item(OpTick, ChanW'($urandom), ValW'($urandom));
  endtask

  // A write whose low time comes out a few ticks long at the current settings.
  task automatic send_channel(input int chan);
    int unsigned us;
    us = (cur_pulse + cur_tpu - 1) / cur_tpu + $urandom_range(0, 2);
    send_item(OpWrite, ChanW'(chan), us[ValW-1:0]);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Write all three registers on consecutive cycles.
  task automatic configure(input int tpu, input int pulse, input int frame);
    cur_tpu   = TpuW'(tpu);
    cur_pulse = TickW'(pulse);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTicksPerUs;
    cfg_data <= CfgDataW'(tpu);
    tracker.set_config(CfgTicksPerUs, CfgDataW'(tpu));
    @(posedge clk);
    cfg_idx  <= CfgPulseTicks;
    cfg_data <= CfgDataW'(pulse);
    tracker.set_config(CfgPulseTicks, CfgDataW'(pulse));
    @(posedge clk);
    cfg_idx  <= CfgFrameTicks;
    cfg_data <= CfgDataW'(frame);
    tracker.set_config(CfgFrameTicks, CfgDataW'(frame));
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Small pulses and a frame length that keeps the padding short.
  task automatic configure_short_frames();
    int pulse;
    pulse = $urandom_range(1, 4);
    configure($urandom_range(1, 3), pulse, 5 * pulse + 40 + $urandom_range(0, 6));
  endtask

  // Mostly ticks with well-formed writes; wild phases write anything anywhere.
  // Ignored writes past the last channel are not counted.
  task automatic run_phase(input int items, input int tick_pct, input bit wild,
                           input int hold_at, input int pause_at);
    int               done;
    int               pick;
    logic [ChanW-1:0] chan;
    done = 0;
    while (done < items) begin
      if (done == hold_at) begin
        hold_request = 1'b1;
        hold_at      = -1;
      end
      if (done == pause_at) begin
        wait_idle();
        pause_at = -1;
      end
      pick = $urandom_range(0, 99);
      chan = ChanW'($urandom_range(0, 7));
      if (pick < tick_pct) begin
        send_tick();
        done++;
      end else if (wild) begin
        send_item(OpWrite, chan, ValW'($urandom));
        if (chan < NumChannels) done++;
      end else if (pick < tick_pct + 4) begin
        send_item(OpWrite, ChanW'(NumChannels + $urandom_range(0, 7 - NumChannels)),
                  ValW'($urandom));
      end else begin
        send_channel($urandom_range(0, NumChannels - 1));
        done++;
      end
    end
  endtask

  initial begin
    tracker             = new(NumChannels);
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgTicksPerUs;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OpTick;
    in_if.channel_index = '0;
    in_if.value_us      = '0;
    out_if.ready        = 1'b0;
    hold_request        = 1'b0;
    hold_left           = 0;
    rx_gap              = 0;
    idling              = 1'b1;
    cur_tpu             = TicksPerUsRst;
    cur_pulse           = PulseTicksRst;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset configuration: channel values that wrap
    // below zero and past 16 bits, ignored high indexes, a zero low time
    // and an overwrite that has to leave the running sum consistent.
    send_item(OpWrite, 3'd0, 16'd0);
    send_item(OpWrite, 3'd4, 16'hFFFF);
    send_item(OpWrite, 3'd5, 16'hFFFF);
    send_item(OpWrite, 3'd7, 16'd0);
    send_item(OpWrite, 3'd6, 16'hAAAA);
    send_item(OpWrite, 3'd1, 16'h5555);
    send_item(OpWrite, 3'd2, 16'd300);
    send_item(OpWrite, 3'd3, 16'd301);
    send_item(OpTick, 3'd7, 16'hFFFF);
    send_item(OpTick, 3'd0, 16'd0);
    send_item(OpWrite, 3'd0, 16'hAAAA);
    repeat (4) send_tick();

    // First frame: the reset interval must run out before the line moves,
    // so this phase is long and almost all ticks.
    wait_idle();
    configure(1, 2, 10 + 40 + $urandom_range(0, 6));
    for (int ch = 0; ch < NumChannels; ch++) send_channel(ch);
    run_phase(720, 95, 1'b0, -1, -1);

    // Long receiver hold-off, then a full drain by the sender.
    wait_idle();
    configure_short_frames();
    run_phase(180, 85, 1'b0, 40, 120);

    // A stretch without idling on either side.
    wait_idle();
    idling = 1'b0;
    configure_short_frames();
    run_phase(180, 85, 1'b0, -1, -1);

    wait_idle();
    idling = 1'b1;
    configure_short_frames();
    run_phase(120, 80, 1'b0, 30, -1);

    // Extreme register values, with no idling from here on.
    wait_idle();
    idling = 1'b0;
    configure(255, 65535, 65535);
    run_phase(25, 50, 1'b1, -1, -1);

    wait_idle();
    configure(1, 1, 1);
    run_phase(25, 50, 1'b1, -1, -1);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("** ppm_frame_generator: PASSED **");
    end else begin
      $display("** ppm_frame_generator: FAILED **");
    end
    $finish;
  end

endmodule
